// ===== src/set_assoc_cache_lru_wb_core_defines.svh =====
// Assertion helpers shared by the cache core. Both sample on the rising edge
// of clk and are switched off while rst_n is low.
`ifndef SET_ASSOC_CACHE_LRU_WB_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_WB_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sacl_pkg.sv =====
package sacl_pkg;

  localparam int unsigned MAX_SETS_DEF   = 64;
  localparam int unsigned WAYS_DEF       = 8;
  localparam int unsigned ADDR_WIDTH_DEF = 64;

  localparam int unsigned IN_ADDR_W = 64;
  localparam int unsigned SETB_W    = 3;
  localparam int unsigned OFFB_W    = 4;
  localparam int unsigned WAYSB_W   = 4;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned BYTES_W   = 40;

  // Ways in use never exceed sixteen, so five bits always hold the count.
  localparam int unsigned NWAY_W = 5;

  localparam int unsigned AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
  // A fill ages every other valid way, so its limit lies above any age.
  localparam logic [AGE_W:0] AGE_LIM_FILL = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } meta_t;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic evicted_dirty;
    logic made_dirty;
  } outcome_t;

endpackage

// ===== src/sacl_addr_map.sv =====
module sacl_addr_map import sacl_pkg::*; #(
  parameter int unsigned MAX_SETS   = MAX_SETS_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF,
  localparam int unsigned SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic [ADDR_WIDTH-1:0] addr,
  input  logic [SETB_W-1:0]     set_bits,
  input  logic [OFFB_W-1:0]     off_bits,
  output logic [ADDR_WIDTH-1:0] blk,
  output logic [SET_W-1:0]      set_idx
);

  localparam int unsigned SEL_W  = (1 << SETB_W) - 1;
  localparam int unsigned MASK_W = SEL_W + 1;
  localparam int unsigned LUT_N  = 1 << SEL_W;

  logic [MASK_W-1:0] sel_mask;
  logic [SEL_W-1:0]  sel_raw;
  logic [SET_W-1:0]  set_lut [LUT_N];

  // The set number wraps modulo the number of sets held; the raw select is
  // narrow, so the wrap is a constant table.
  for (genvar i = 0; i < LUT_N; i++) begin : g_set_lut
    localparam int unsigned SET_V = i % MAX_SETS;
    assign set_lut[i] = SET_W'(SET_V);
  end

  assign blk      = addr >> off_bits;
  assign sel_mask = (MASK_W'(1) << set_bits) - MASK_W'(1);
  assign sel_raw  = blk[SEL_W-1:0] & sel_mask[SEL_W-1:0];
  assign set_idx  = set_lut[sel_raw];

endmodule

// ===== src/sacl_set_update.sv =====
module sacl_set_update import sacl_pkg::*; #(
  parameter int unsigned WAYS       = WAYS_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF,
  localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [ADDR_WIDTH-1:0]           blk,
  input  logic                            cmd,
  input  logic [WAYSB_W-1:0]              ways_in_use,
  input  logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_row,
  input  meta_t [WAYS-1:0]                meta_row,
  output logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_new,
  output meta_t [WAYS-1:0]                meta_new,
  output logic                            tag_we,
  output outcome_t                        outcome
);

  logic [NWAY_W-1:0] nways;
  logic [WAYS-1:0]   use_w;
  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   inv_vec;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  way_sel;
  logic [AGE_W-1:0]  best_age;
  logic [AGE_W:0]    age_lim;
  logic              hit;
  logic              found;
  logic              is_store;

  assign is_store = (cmd == CMD_STORE);

  always_comb begin
    if (ways_in_use == '0) begin
      nways = NWAY_W'(1);
    end else if ({1'b0, ways_in_use} > NWAY_W'(WAYS)) begin
      nways = NWAY_W'(WAYS);
    end else begin
      nways = {1'b0, ways_in_use};
    end
    for (int i = 0; i < WAYS; i++) begin
      use_w[i]   = (NWAY_W'(i) < nways);
      hit_vec[i] = use_w[i] & meta_row[i].valid & (tag_row[i] == blk);
      inv_vec[i] = use_w[i] & ~meta_row[i].valid;
    end
  end

  // Lowest matching index wins, for the hit search and for the free way.
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (inv_vec[i]) begin
        inv_way = WAY_W'(i);
      end
    end
  end

  // Oldest way; a strict compare keeps the lowest index on a tie.
  always_comb begin
    best_age = '0;
    lru_way  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (use_w[i] && (meta_row[i].age > best_age)) begin
        best_age = meta_row[i].age;
        lru_way  = WAY_W'(i);
      end
    end
  end

  assign hit   = |hit_vec;
  assign found = |inv_vec;

  always_comb begin
    priority if (hit) begin
      way_sel = hit_way;
    end else if (found) begin
      way_sel = inv_way;
    end else begin
      way_sel = lru_way;
    end
  end

  // On a hit only ways younger than the touched one age.
  assign age_lim = hit ? {1'b0, meta_row[way_sel].age} : AGE_LIM_FILL;

  always_comb begin
    meta_new = meta_row;
    tag_new  = tag_row;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == way_sel) begin
        meta_new[i].valid = 1'b1;
        meta_new[i].dirty = hit ? (meta_row[i].dirty | is_store) : is_store;
        meta_new[i].age   = '0;
      end else if (use_w[i] && meta_row[i].valid &&
                   ({1'b0, meta_row[i].age} < age_lim) && (meta_row[i].age != AGE_MAX)) begin
        meta_new[i].age = meta_row[i].age + AGE_W'(1);
      end
    end
    tag_new[way_sel] = blk;
  end

  assign tag_we                = ~hit;
  assign outcome.hit           = hit;
  assign outcome.evicted       = ~hit & ~found;
  assign outcome.evicted_dirty = ~hit & ~found & meta_row[lru_way].dirty;
  assign outcome.made_dirty    = is_store & ~(hit & meta_row[way_sel].dirty);

endmodule

// ===== src/sacl_stats.sv =====
module sacl_stats import sacl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  outcome_t           outcome,
  input  logic [OFFB_W-1:0]  off_bits,
  output logic [CNT_W-1:0]   hit_total,
  output logic [CNT_W-1:0]   miss_total,
  output logic [CNT_W-1:0]   eviction_total,
  output logic [BYTES_W-1:0] dirty_resident_bytes,
  output logic [BYTES_W-1:0] dirty_evicted_bytes
);

  logic [CNT_W-1:0]   hit_cnt_r;
  logic [CNT_W-1:0]   hit_cnt_nxt;
  logic [CNT_W-1:0]   miss_cnt_r;
  logic [CNT_W-1:0]   miss_cnt_nxt;
  logic [CNT_W-1:0]   evict_cnt_r;
  logic [CNT_W-1:0]   evict_cnt_nxt;
  logic [BYTES_W-1:0] written_r;
  logic [BYTES_W-1:0] written_nxt;
  logic [BYTES_W-1:0] wback_r;
  logic [BYTES_W-1:0] wback_nxt;
  logic [BYTES_W-1:0] blk_bytes;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [BYTES_W-1:0] add_sat(input logic [BYTES_W-1:0] a,
                                                  input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTES_W] ? '1 : s[BYTES_W-1:0];
  endfunction

  assign blk_bytes = BYTES_W'(1) << off_bits;

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    written_nxt   = written_r;
    wback_nxt     = wback_r;
    if (upd) begin
      if (outcome.hit) begin
        hit_cnt_nxt = inc_sat(hit_cnt_r);
      end else begin
        miss_cnt_nxt = inc_sat(miss_cnt_r);
      end
      if (outcome.evicted) begin
        evict_cnt_nxt = inc_sat(evict_cnt_r);
      end
      if (outcome.evicted_dirty) begin
        wback_nxt = add_sat(wback_r, blk_bytes);
      end
      if (outcome.made_dirty) begin
        written_nxt = add_sat(written_r, blk_bytes);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      written_r   <= '0;
      wback_r     <= '0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      written_r   <= written_nxt;
      wback_r     <= wback_nxt;
    end
  end

  assign hit_total            = hit_cnt_r;
  assign miss_total           = miss_cnt_r;
  assign eviction_total       = evict_cnt_r;
  assign dirty_evicted_bytes  = wback_r;
  // Write-backs outgrow the written total if it saturates or the block size grows.
  assign dirty_resident_bytes = (written_r >= wback_r) ? (written_r - wback_r) : '0;

endmodule

// ===== src/set_assoc_cache_lru_wb_core.sv =====
// Channel   Ports                                       Transfer
// access    start, busy, in_cmd, in_address             beat taken when start=1, busy=0
// result    out_strobe, out_hit ... out_dirty_*         one-cycle strobe, no hold-off
// config    cfg_we, cfg_index, cfg_data                 written when cfg_we=1
//
// An access reads the set from the tag and state memories at the accepting edge,
// then compares, updates and writes it back in the next cycle, with busy high
// for that cycle. The result strobe is registered at the end of that cycle; the
// next access may already be taken while it shows, not before the update is done.
// After reset the state memory is cleared one set per cycle, every set in turn
// with busy high; config writes are taken throughout. Results cannot be stalled.
module set_assoc_cache_lru_wb_core import sacl_pkg::*; #(
  parameter int unsigned MAX_SETS   = MAX_SETS_DEF,
  parameter int unsigned WAYS       = WAYS_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [IN_ADDR_W-1:0] in_address,
  output logic                 out_strobe,
  output logic                 out_hit,
  output logic                 out_evicted,
  output logic                 out_evicted_dirty,
  output logic [CNT_W-1:0]     out_hit_total,
  output logic [CNT_W-1:0]     out_miss_total,
  output logic [CNT_W-1:0]     out_eviction_total,
  output logic [BYTES_W-1:0]   out_dirty_resident_bytes,
  output logic [BYTES_W-1:0]   out_dirty_evicted_bytes,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "set_assoc_cache_lru_wb_core_defines.svh"

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                          state_r;
  logic [SET_W-1:0]                clr_idx_r;
  logic                            out_strobe_r;
  logic                            out_hit_r;
  logic                            out_evicted_r;
  logic                            out_evd_r;

  logic [SETB_W-1:0]               set_bits_r;
  logic [OFFB_W-1:0]               off_bits_r;
  logic [WAYSB_W-1:0]              ways_r;

  logic                            cmd_r;
  logic [ADDR_WIDTH-1:0]           blk_r;
  logic [SET_W-1:0]                set_r;

  logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [MAX_SETS];
  meta_t [WAYS-1:0]                meta_mem [MAX_SETS];
  logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_rd_r;
  meta_t [WAYS-1:0]                meta_rd_r;

  logic                            accept;
  logic [ADDR_WIDTH-1:0]           in_blk;
  logic [SET_W-1:0]                in_set;
  logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_new;
  meta_t [WAYS-1:0]                meta_new;
  logic                            tag_fill;
  outcome_t                        outcome;
  logic                            exec;
  logic                            clearing;
  logic                            meta_we;
  logic [SET_W-1:0]                meta_wr_set;
  meta_t [WAYS-1:0]                meta_wr_row;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start & ~busy;
  assign exec     = (state_r == S_EXEC);
  assign clearing = (state_r == S_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= '0;
      off_bits_r <= '0;
      ways_r     <= WAYSB_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_data[SETB_W-1:0];
        CFG_OFF_BITS: off_bits_r <= cfg_data[OFFB_W-1:0];
        CFG_WAYS:     ways_r     <= cfg_data[WAYSB_W-1:0];
        default:      ;
      endcase
    end
  end

  sacl_addr_map #(
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_addr_map (
    .addr     (in_address[ADDR_WIDTH-1:0]),
    .set_bits (set_bits_r),
    .off_bits (off_bits_r),
    .blk      (in_blk),
    .set_idx  (in_set)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      blk_r <= in_blk;
      set_r <= in_set;
    end
  end

  // Reads happen only when a beat is taken and writes only while busy, so a
  // later access to the same set always sees the written-back row.
  assign meta_we     = clearing | exec;
  assign meta_wr_set = clearing ? clr_idx_r : set_r;
  assign meta_wr_row = clearing ? '0 : meta_new;

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_rd_r  <= tag_mem[in_set];
      meta_rd_r <= meta_mem[in_set];
    end
    if (exec && tag_fill) begin
      tag_mem[set_r] <= tag_new;
    end
    if (meta_we) begin
      meta_mem[meta_wr_set] <= meta_wr_row;
    end
  end

  sacl_set_update #(
    .WAYS       (WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_set_update (
    .blk         (blk_r),
    .cmd         (cmd_r),
    .ways_in_use (ways_r),
    .tag_row     (tag_rd_r),
    .meta_row    (meta_rd_r),
    .tag_new     (tag_new),
    .meta_new    (meta_new),
    .tag_we      (tag_fill),
    .outcome     (outcome)
  );

  sacl_stats u_stats (
    .clk                  (clk),
    .rst_n                (rst_n),
    .upd                  (exec),
    .outcome              (outcome),
    .off_bits             (off_bits_r),
    .hit_total            (out_hit_total),
    .miss_total           (out_miss_total),
    .eviction_total       (out_eviction_total),
    .dirty_resident_bytes (out_dirty_resident_bytes),
    .dirty_evicted_bytes  (out_dirty_evicted_bytes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      out_strobe_r  <= 1'b0;
      out_hit_r     <= 1'b0;
      out_evicted_r <= 1'b0;
      out_evd_r     <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          if (clr_idx_r == SET_W'(MAX_SETS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + SET_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r       <= S_IDLE;
          out_strobe_r  <= 1'b1;
          out_hit_r     <= outcome.hit;
          out_evicted_r <= outcome.evicted;
          out_evd_r     <= outcome.evicted_dirty;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_hit           = out_hit_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_dirty = out_evd_r;

  `SACL_ASSERT_NEXT(a_accept_to_exec, accept, state_r == S_EXEC, "accepted beat did not start work")
  `SACL_ASSERT_NEXT(a_exec_strobes, state_r == S_EXEC, out_strobe_r && !busy, "work ended without a result")
  `SACL_ASSERT_SAME(a_strobe_source, out_strobe_r, $past(state_r) == S_EXEC, "result without work")
  `SACL_ASSERT_SAME(a_evict_is_miss, out_strobe_r && out_evd_r, out_evicted_r && !out_hit_r, "dirty eviction on a hit")

endmodule

// ===== tb/sv/set_assoc_cache_lru_wb_core_test.sv =====
`timescale 1ns / 1ps

module set_assoc_cache_lru_wb_core_test;
  import sacl_pkg::*;

  localparam int unsigned LINES        = MAX_SETS_DEF * WAYS_DEF;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [63:0] BYTES_CAP    = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_CAP = '1;
  // Index three selects no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic               evicted_dirty;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    logic [CNT_W-1:0]   evictions;
    logic [BYTES_W-1:0] resident;
    logic [BYTES_W-1:0] written_back;
  } access_report_t;

  typedef enum bit {ROW_CONFIG, ROW_ACCESS} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic                 cmd;
    logic [63:0]          addr;
    bit                   typed;
    access_report_t       want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 start      = 1'b0;
  logic                 busy;
  logic                 in_cmd     = CMD_LOAD;
  logic [IN_ADDR_W-1:0] in_address = '0;
  logic                 out_strobe;
  logic                 out_hit;
  logic                 out_evicted;
  logic                 out_evicted_dirty;
  logic [CNT_W-1:0]     out_hit_total;
  logic [CNT_W-1:0]     out_miss_total;
  logic [CNT_W-1:0]     out_eviction_total;
  logic [BYTES_W-1:0]   out_dirty_resident_bytes;
  logic [BYTES_W-1:0]   out_dirty_evicted_bytes;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  // Shadow copy of the cache: tags, line state and the running totals.
  logic [63:0]      line_tag   [LINES];
  bit               line_valid [LINES];
  bit               line_dirty [LINES];
  logic [AGE_W-1:0] line_age   [LINES];
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] evict_count;
  logic [63:0]      bytes_dirtied;
  logic [63:0]      bytes_written_back;
  int unsigned      cache_set_bits;
  int unsigned      cache_off_bits;
  int unsigned      cache_ways;

  access_report_t expected_reports [$];
  stim_row_t      stim_rows [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned accesses;
  int unsigned hits_seen;
  int unsigned evictions_seen;
  int unsigned dirty_evictions_seen;
  int unsigned settings_used;
  int unsigned cycle_count;

  set_assoc_cache_lru_wb_core u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_cmd                   (in_cmd),
    .in_address               (in_address),
    .out_strobe               (out_strobe),
    .out_hit                  (out_hit),
    .out_evicted              (out_evicted),
    .out_evicted_dirty        (out_evicted_dirty),
    .out_hit_total            (out_hit_total),
    .out_miss_total           (out_miss_total),
    .out_eviction_total       (out_eviction_total),
    .out_dirty_resident_bytes (out_dirty_resident_bytes),
    .out_dirty_evicted_bytes  (out_dirty_evicted_bytes),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
    return (v == CNT_CAP) ? v : v + 1'b1;
  endfunction

  function automatic logic [63:0] add_bytes(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > BYTES_CAP) ? BYTES_CAP : s;
  endfunction

  // Makes way w the most recently used; valid ways younger than limit grow older.
  function automatic void promote_way(int unsigned base, int unsigned nways,
                                      int unsigned w, int unsigned limit);
    for (int unsigned i = 0; i < nways; i++) begin
      if (i != w && line_valid[base+i] && line_age[base+i] < limit &&
          line_age[base+i] < AGE_MAX)
        line_age[base+i] = line_age[base+i] + AGE_W'(1);
    end
    line_age[base+w] = '0;
  endfunction

  function automatic access_report_t predict_access(logic cmd, logic [63:0] addr);
    access_report_t rep;
    logic [63:0]    blk;
    logic [63:0]    blk_bytes;
    logic [63:0]    set_mask;
    int unsigned    set_no;
    int unsigned    nways;
    int unsigned    base;
    int unsigned    w;
    int unsigned    best;
    bit             found;
    rep       = '0;
    blk       = addr >> cache_off_bits;
    blk_bytes = 64'd1 << cache_off_bits;
    set_mask  = (64'd1 << cache_set_bits) - 64'd1;
    set_no    = 32'((blk & set_mask) % MAX_SETS_DEF);
    nways     = (cache_ways == 0) ? 1 : ((cache_ways > WAYS_DEF) ? WAYS_DEF : cache_ways);
    base      = set_no * WAYS_DEF;
    w         = 0;
    found     = 1'b0;
    for (int unsigned i = 0; i < nways; i++) begin
      if (!rep.hit && line_valid[base+i] && line_tag[base+i] == blk) begin
        rep.hit = 1'b1;
        w       = i;
      end
    end
    if (rep.hit) begin
      hit_count = count_up(hit_count);
      promote_way(base, nways, w, 32'(line_age[base+w]));
    end else begin
      miss_count = count_up(miss_count);
      for (int unsigned i = 0; i < nways; i++) begin
        if (!found && !line_valid[base+i]) begin
          found = 1'b1;
          w     = i;
        end
      end
      if (!found) begin
        // Oldest way goes; on equal ages the lowest index wins.
        best = 0;
        w    = 0;
        for (int unsigned i = 0; i < nways; i++) begin
          if (line_age[base+i] > best) begin
            best = 32'(line_age[base+i]);
            w    = i;
          end
        end
        rep.evicted = 1'b1;
        evict_count = count_up(evict_count);
        if (line_dirty[base+w]) begin
          rep.evicted_dirty  = 1'b1;
          bytes_written_back = add_bytes(bytes_written_back, blk_bytes);
        end
      end
      line_valid[base+w] = 1'b1;
      line_dirty[base+w] = 1'b0;
      line_tag[base+w]   = blk;
      promote_way(base, nways, w, 32'(AGE_LIM_FILL));
    end
    if (cmd == CMD_STORE && !line_dirty[base+w]) begin
      line_dirty[base+w] = 1'b1;
      bytes_dirtied      = add_bytes(bytes_dirtied, blk_bytes);
    end
    rep.hits         = hit_count;
    rep.misses       = miss_count;
    rep.evictions    = evict_count;
    rep.resident     = (bytes_dirtied >= bytes_written_back) ?
                       BYTES_W'(bytes_dirtied - bytes_written_back) : '0;
    rep.written_back = BYTES_W'(bytes_written_back);
    return rep;
  endfunction

  function automatic void add_config_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row         = '{kind: ROW_CONFIG, default: '0};
    row.reg_idx = idx;
    row.reg_val = val;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_access_row(logic cmd, logic [63:0] addr);
    stim_row_t row;
    row      = '{kind: ROW_ACCESS, default: '0};
    row.cmd  = cmd;
    row.addr = addr;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed_row(logic cmd, logic [63:0] addr, logic hit, logic ev,
                                        logic evd, int unsigned hits, int unsigned misses,
                                        int unsigned evictions, longint unsigned resident,
                                        longint unsigned written_back);
    stim_row_t row;
    row                   = '{kind: ROW_ACCESS, default: '0};
    row.cmd               = cmd;
    row.addr              = addr;
    row.typed             = 1'b1;
    row.want.hit          = hit;
    row.want.evicted      = ev;
    row.want.evicted_dirty = evd;
    row.want.hits         = hits;
    row.want.misses       = misses;
    row.want.evictions    = evictions;
    row.want.resident     = BYTES_W'(resident);
    row.want.written_back = BYTES_W'(written_back);
    stim_rows.push_back(row);
  endfunction

  function automatic void flag_mismatch(string what, access_report_t want,
                                        access_report_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  expected hit=%0d ev=%0d evd=%0d hits=%0d misses=%0d evictions=%0d",
               want.hit, want.evicted, want.evicted_dirty, want.hits, want.misses,
               want.evictions);
      $display("           resident=%0d written_back=%0d", want.resident, want.written_back);
      $display("  actual   hit=%0d ev=%0d evd=%0d hits=%0d misses=%0d evictions=%0d",
               got.hit, got.evicted, got.evicted_dirty, got.hits, got.misses, got.evictions);
      $display("           resident=%0d written_back=%0d", got.resident, got.written_back);
    end
  endfunction

  // Each beat is taken at an edge where start is high and busy was low.
  task automatic send_access(input logic cmd, input logic [63:0] addr, input bit typed,
                             input access_report_t typed_rep);
    access_report_t rep;
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    rep = predict_access(cmd, addr);
    expected_reports.push_back(typed ? typed_rep : rep);
    accesses++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SET_BITS: cache_set_bits = 32'(val & 4'h7);
      CFG_OFF_BITS: cache_off_bits = 32'(val);
      CFG_WAYS:     cache_ways     = 32'(val);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_reports.size());
      $display("set_assoc_cache_lru_wb_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    access_report_t got;
    access_report_t want;
    if (rst_n && out_strobe) begin
      got.hit           = out_hit;
      got.evicted       = out_evicted;
      got.evicted_dirty = out_evicted_dirty;
      got.hits          = out_hit_total;
      got.misses        = out_miss_total;
      got.evictions     = out_eviction_total;
      got.resident      = out_dirty_resident_bytes;
      got.written_back  = out_dirty_evicted_bytes;
      results_seen++;
      if (got.hit === 1'b1) hits_seen++;
      if (got.evicted === 1'b1) evictions_seen++;
      if (got.evicted_dirty === 1'b1) dirty_evictions_seen++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("Result with no access outstanding", '0, got);
      end else begin
        want = expected_reports.pop_front();
        if (got.hit !== want.hit || got.evicted !== want.evicted ||
            got.evicted_dirty !== want.evicted_dirty || got.hits !== want.hits ||
            got.misses !== want.misses || got.evictions !== want.evictions ||
            got.resident !== want.resident || got.written_back !== want.written_back)
          flag_mismatch("Result differs", want, got);
      end
    end
  end

  initial begin
    logic [63:0]      addr_pool [64];
    logic [63:0]      off_mask;
    logic [63:0]      set_mask;
    logic [63:0]      addr;
    logic             cmd;
    int unsigned      pool_size;
    int unsigned      idle_pct;
    int unsigned      sb;
    int unsigned      ob;
    int unsigned      ways;
    access_report_t   no_rep;
    mismatches           = 0;
    results_seen         = 0;
    accesses             = 0;
    hits_seen            = 0;
    evictions_seen       = 0;
    dirty_evictions_seen = 0;
    settings_used        = 0;
    cycle_count          = 0;
    no_rep               = '0;
    for (int unsigned i = 0; i < LINES; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_age[i]   = '0;
    end
    hit_count          = '0;
    miss_count         = '0;
    evict_count        = '0;
    bytes_dirtied      = '0;
    bytes_written_back = '0;
    cache_set_bits     = 0;
    cache_off_bits     = 0;
    cache_ways         = 1;

    // Out of reset: one set, byte-sized blocks, direct mapped.
    add_typed_row(CMD_LOAD, 64'h0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_typed_row(CMD_STORE, 64'h0, 1, 0, 0, 1, 1, 0, 1, 0);
    add_typed_row(CMD_LOAD, '1, 0, 1, 1, 1, 2, 1, 0, 1);
    add_typed_row(CMD_STORE, '1, 1, 0, 0, 2, 2, 1, 1, 1);
    // Zero ways behaves as one; the write-back at the larger block size
    // outgrows the bytes dirtied, so the resident total clamps at zero.
    add_config_row(CFG_WAYS, 4'd0);
    add_config_row(CFG_OFF_BITS, 4'd12);
    add_typed_row(CMD_LOAD, 64'h8000_0000_0000_0000, 0, 1, 1, 2, 3, 2, 0, 4097);
    add_typed_row(CMD_STORE, 64'h8000_0000_0000_0000, 1, 0, 0, 3, 3, 2, 1, 4097);
    // Ways above the maximum, set bits beyond the set count and the largest
    // blocks; nine stores all land in set zero and saturate the ages.
    add_config_row(CFG_UNUSED_IDX, 4'hF);
    add_config_row(CFG_WAYS, 4'd15);
    add_config_row(CFG_SET_BITS, 4'hF);
    add_config_row(CFG_OFF_BITS, 4'd15);
    for (int unsigned k = 1; k <= 9; k++) add_access_row(CMD_STORE, 64'(k) << 21);
    add_access_row(CMD_LOAD, 64'd3 << 21);
    add_access_row(CMD_STORE, 64'd9 << 21);
    // Shrink the blocks so lines dirtied at the large size are written back small.
    add_config_row(CFG_OFF_BITS, 4'd0);
    add_config_row(CFG_WAYS, 4'd2);
    add_config_row(CFG_SET_BITS, 4'd1);
    add_access_row(CMD_LOAD, 64'h1);
    add_access_row(CMD_LOAD, 64'h3);
    add_access_row(CMD_LOAD, 64'h5);
    add_access_row(CMD_STORE, 64'h0);
    add_config_row(CFG_WAYS, 4'd8);
    add_config_row(CFG_OFF_BITS, 4'd13);
    add_config_row(CFG_SET_BITS, 4'd6);
    add_access_row(CMD_STORE, '1);
    add_access_row(CMD_LOAD, 64'h1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CONFIG) begin
        drain_results();
        write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
      end else begin
        send_access(stim_rows[r].cmd, stim_rows[r].addr, stim_rows[r].typed,
                    stim_rows[r].want);
      end
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin sb = 7; ob = 15; ways = 15; end
        1: begin sb = 0; ob = 0;  ways = 1;  end
        2: begin sb = 6; ob = 12; ways = 8;  end
        3: begin sb = 2; ob = 3;  ways = 0;  end
        default: begin
          sb   = $urandom_range(0, 7);
          ob   = $urandom_range(0, 15);
          ways = $urandom_range(0, 15);
        end
      endcase
      write_reg(CFG_SET_BITS, {1'($urandom_range(0, 1)), 3'(sb)});
      write_reg(CFG_OFF_BITS, 4'(ob));
      write_reg(CFG_WAYS, 4'(ways));
      settings_used++;

      // A small pool of blocks gives reuse; about half of them are pushed into two
      // sets so that replacement is exercised hard.
      off_mask  = (64'd1 << ob) - 64'd1;
      set_mask  = ((64'd1 << sb) - 64'd1) << ob;
      pool_size = $urandom_range(2, 48);
      for (int unsigned p = 0; p < pool_size; p++) begin
        addr_pool[p] = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1)
          addr_pool[p] = (addr_pool[p] & ~set_mask) |
                         ((64'($urandom_range(0, 1)) << ob) & set_mask);
      end
      idle_pct = (phase == PHASES - 1) ? 0 : $urandom_range(0, 50);

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd = ($urandom_range(0, 1) == 1) ? CMD_STORE : CMD_LOAD;
        if ($urandom_range(0, 99) < 15)
          addr = {$urandom, $urandom};
        else
          addr = addr_pool[$urandom_range(0, pool_size - 1)] ^ ({$urandom, $urandom} & off_mask);
        send_access(cmd, addr, 1'b0, no_rep);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0d results never arrived", expected_reports.size());
      mismatches += expected_reports.size();
    end
    $display("Ran %0d accesses over %0d random cache settings plus directed rows;",
             accesses, settings_used);
    $display("checked %0d results: %0d hits, %0d evictions, %0d of them dirty.",
             results_seen, hits_seen, evictions_seen, dirty_evictions_seen);
    if (mismatches == 0)
      $display("set_assoc_cache_lru_wb_core: match");
    else
      $display("set_assoc_cache_lru_wb_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sacl_pkg.sv
src/sacl_addr_map.sv
src/sacl_set_update.sv
src/sacl_stats.sv
src/set_assoc_cache_lru_wb_core.sv
tb/sv/set_assoc_cache_lru_wb_core_test.sv
